>>> design/azbc_pkg.sv
// ----------------------------------------------------------------------------
// azbc_pkg
// Shared types, codes and constants for the ambient light zoned backlight
// controller.
// ----------------------------------------------------------------------------
package azbc_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int LEVEL_W  = 8;
    localparam int SAMPLE_W = 10;
    localparam int PCT_W    = 7;
    localparam int WORD_W   = 16;
    localparam int ZONE_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_BRIGHT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MODE   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZONE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFF   = 3'd6;

    // light zones
    localparam int NUM_ZONES = 5;
    localparam logic [SAMPLE_W-1:0] ZONE_LIMIT [NUM_ZONES] =
        '{10'd150, 10'd300, 10'd450, 10'd600, 10'd750};

    // divide by 100 as multiply by ceil(2^22 / 100) and shift; exact for
    // products below 2^15, the largest being 255 * 127
    localparam int DIV_SHIFT = 22;
    localparam logic [15:0] DIV_MULT = 16'd41944;
    localparam int FACTOR_W = PCT_W + 16;
    localparam int PROD_W   = LEVEL_W + FACTOR_W;
    localparam int SCALED_W = PROD_W - DIV_SHIFT;
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd100;

    // pwm duty placement in the backlight word
    localparam int DUTY_LSB = 5;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [LEVEL_W-1:0]  brightness;
        logic [SAMPLE_W-1:0] light_sample;
        logic                mode_request;
    } item_t;

    typedef struct packed {
        logic                write_strobe;
        logic [WORD_W-1:0]   backlight_word;
        logic                power_on;
        logic [ZONE_W-1:0]   zone;
        logic                mode_now;
        logic                sensor_invalid;
    } result_t;

    // percent registers held as premultiplied scale factors
    typedef struct packed {
        logic [NUM_ZONES-1:0][FACTOR_W-1:0] factor;
        logic [WORD_W-1:0]                  base_bits;
        logic [WORD_W-1:0]                  off_word;
    } cfg_t;

endpackage

>>> design/azbc_in_if.sv
// ----------------------------------------------------------------------------
// azbc_in_if
// Command item channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface azbc_in_if;
    import azbc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [LEVEL_W-1:0]  brightness;
    logic [SAMPLE_W-1:0] light_sample;
    logic                mode_request;

    modport source (output valid, output cmd, output brightness,
                    output light_sample, output mode_request, input ready);
    modport sink   (input valid, input cmd, input brightness,
                    input light_sample, input mode_request, output ready);
endinterface

>>> design/azbc_out_if.sv
// ----------------------------------------------------------------------------
// azbc_out_if
// Result item channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface azbc_out_if;
    import azbc_pkg::*;

    logic              valid;
    logic              ready;
    logic              write_strobe;
    logic [WORD_W-1:0] backlight_word;
    logic              power_on;
    logic [ZONE_W-1:0] zone;
    logic              mode_now;
    logic              sensor_invalid;

    modport source (output valid, output write_strobe, output backlight_word,
                    output power_on, output zone, output mode_now,
                    output sensor_invalid, input ready);
    modport sink   (input valid, input write_strobe, input backlight_word,
                    input power_on, input zone, input mode_now,
                    input sensor_invalid, output ready);
endinterface

>>> design/azbc_cfg.sv
// ----------------------------------------------------------------------------
// azbc_cfg
// Configuration registers; zone percentages are stored as scale factors
// premultiplied by the divide-by-100 reciprocal.
// ----------------------------------------------------------------------------
module azbc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [azbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [azbc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output azbc_pkg::cfg_t                      cfg
);
    import azbc_pkg::*;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET =
        FACTOR_W'(PCT_RESET) * FACTOR_W'(DIV_MULT);

    logic [NUM_ZONES-1:0][FACTOR_W-1:0] factor_reg;
    logic [WORD_W-1:0]                  base_reg;
    logic [WORD_W-1:0]                  off_reg;
    logic [FACTOR_W-1:0]                factor_new;

    // percent times reciprocal
    assign factor_new = FACTOR_W'(cfg_data[PCT_W-1:0]) * FACTOR_W'(DIV_MULT);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ZONES; i++)
            begin
                factor_reg[i] <= FACTOR_RESET;
            end
            base_reg <= '0;
            off_reg  <= '0;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < NUM_ZONES; i++)
            begin
                if (cfg_index == REG_ZONE0 + CFG_IDX_W'(i))
                begin
                    factor_reg[i] <= factor_new;
                end
            end
            if (cfg_index == REG_BASE)
            begin
                base_reg <= cfg_data[WORD_W-1:0];
            end
            if (cfg_index == REG_OFF)
            begin
                off_reg <= cfg_data[WORD_W-1:0];
            end
        end
    end

    assign cfg.factor    = factor_reg;
    assign cfg.base_bits = base_reg;
    assign cfg.off_word  = off_reg;

    // a zone write never touches the word registers
    ap_zone_write_keeps_base : assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index <= REG_ZONE4) |=> $stable(base_reg) && $stable(off_reg))
        else $error("zone percent write changed a word register");

    ap_off_write : assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_OFF) |=> off_reg == $past(cfg_data))
        else $error("off word not loaded");

    ap_base_write : assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_BASE) |=> base_reg == $past(cfg_data))
        else $error("base bits not loaded");

endmodule

>>> design/azbc_engine.sv
// ----------------------------------------------------------------------------
// azbc_engine
// Controller state and the single-pass result logic for one command item.
// ----------------------------------------------------------------------------
module azbc_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  azbc_pkg::item_t   item,
    input  azbc_pkg::cfg_t    cfg,
    output azbc_pkg::result_t res
);
    import azbc_pkg::*;

    logic                auto_mode_reg, auto_mode_next;
    logic [LEVEL_W-1:0]  saved_level_reg, saved_level_next;
    logic [FACTOR_W-1:0] factor_now_reg, factor_now_next;
    logic [ZONE_W-1:0]   last_zone_reg, last_zone_next;
    logic                panel_awake_reg, panel_awake_next;
    logic                supply_on_reg, supply_on_next;

    logic [ZONE_W-1:0]   zone_sel;
    logic                over_range;
    logic [FACTOR_W-1:0] zone_factor;
    logic [LEVEL_W-1:0]  lvl_src;
    logic [FACTOR_W-1:0] fac_src;
    logic [PROD_W-1:0]   product;
    logic [SCALED_W-1:0] scaled;
    logic                strobe;
    logic [WORD_W-1:0]   word;

    function automatic logic [WORD_W-1:0] make_word(
        input logic [SCALED_W-1:0] level,
        input logic [WORD_W-1:0]   base
    );
        logic [WORD_W-1:0] duty;
        duty = WORD_W'(level[SCALED_W-1:1]) << DUTY_LSB;
        return duty | base;
    endfunction

    // light zone from fixed thresholds
    always_comb
    begin
        zone_sel   = '0;
        over_range = 1'b1;
        for (int i = NUM_ZONES - 1; i >= 0; i--)
        begin
            if (item.light_sample <= ZONE_LIMIT[i])
            begin
                zone_sel   = ZONE_W'(i);
                over_range = 1'b0;
            end
        end
    end

    // factor of the sampled zone
    always_comb
    begin
        zone_factor = cfg.factor[0];
        for (int i = 0; i < NUM_ZONES; i++)
        begin
            if (zone_sel == ZONE_W'(i))
            begin
                zone_factor = cfg.factor[i];
            end
        end
    end

    // one shared scaler: level * percent / 100
    assign lvl_src = (item.cmd == CMD_BRIGHT) ? item.brightness : saved_level_reg;
    assign fac_src = (item.cmd == CMD_SAMPLE) ? zone_factor : factor_now_reg;
    assign product = PROD_W'(lvl_src) * PROD_W'(fac_src);
    assign scaled  = product[PROD_W-1:DIV_SHIFT];

    // command decode and next state
    always_comb
    begin
        auto_mode_next   = auto_mode_reg;
        saved_level_next = saved_level_reg;
        factor_now_next  = factor_now_reg;
        last_zone_next   = last_zone_reg;
        panel_awake_next = panel_awake_reg;
        supply_on_next   = supply_on_reg;
        strobe           = 1'b0;
        word             = '0;
        case (item.cmd)
            CMD_BRIGHT:
            begin
                strobe = 1'b1;
                if (item.brightness != '0)
                begin
                    supply_on_next   = 1'b1;
                    panel_awake_next = 1'b1;
                    saved_level_next = item.brightness;
                    if (auto_mode_reg)
                    begin
                        word = make_word(scaled, cfg.base_bits);
                    end
                    else
                    begin
                        word = make_word(SCALED_W'(item.brightness), cfg.base_bits);
                    end
                end
                else
                begin
                    supply_on_next   = 1'b0;
                    panel_awake_next = 1'b0;
                    word             = cfg.off_word;
                end
            end
            CMD_SAMPLE:
            begin
                if (!over_range)
                begin
                    factor_now_next = zone_factor;
                    last_zone_next  = zone_sel;
                    if (zone_sel != last_zone_reg && panel_awake_reg)
                    begin
                        strobe = 1'b1;
                        word   = make_word(scaled, cfg.base_bits);
                    end
                end
            end
            CMD_MODE:
            begin
                strobe         = 1'b1;
                auto_mode_next = item.mode_request;
                if (item.mode_request)
                begin
                    word = make_word(scaled, cfg.base_bits);
                end
                else
                begin
                    word = make_word(SCALED_W'(saved_level_reg), cfg.base_bits);
                end
            end
            default:
            begin
                strobe = 1'b0;
            end
        endcase
    end

    // state update when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_mode_reg   <= 1'b1;
            saved_level_reg <= '0;
            factor_now_reg  <= '0;
            last_zone_reg   <= '0;
            panel_awake_reg <= 1'b0;
            supply_on_reg   <= 1'b0;
        end
        else if (advance)
        begin
            auto_mode_reg   <= auto_mode_next;
            saved_level_reg <= saved_level_next;
            factor_now_reg  <= factor_now_next;
            last_zone_reg   <= last_zone_next;
            panel_awake_reg <= panel_awake_next;
            supply_on_reg   <= supply_on_next;
        end
    end

    assign res.write_strobe   = strobe;
    assign res.backlight_word = word;
    assign res.power_on       = supply_on_next;
    assign res.zone           = last_zone_next;
    assign res.mode_now       = auto_mode_next;
    assign res.sensor_invalid = (item.cmd == CMD_SAMPLE) && over_range;

    // supply and panel always switch together
    ap_supply_tracks_panel : assert property (@(posedge clk) disable iff (!rst_n)
        supply_on_reg == panel_awake_reg)
        else $error("supply and panel state diverged");

    ap_zone_range : assert property (@(posedge clk) disable iff (!rst_n)
        last_zone_reg < ZONE_W'(NUM_ZONES))
        else $error("zone out of range");

    ap_idle_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(last_zone_reg) && $stable(saved_level_reg)
                     && $stable(auto_mode_reg))
        else $error("state changed without an item");

endmodule

>>> design/als_zone_backlight_controller_top.sv
// ----------------------------------------------------------------------------
// als_zone_backlight_controller_top
// Ambient light zoned backlight controller: command items in, one backlight
// result item out per command.
// ----------------------------------------------------------------------------
// an accepted item is held in the input register and its result is registered
// in the result register once that register is free
// throughput: one item per cycle while results are taken; input register feeds the result register
// through one 8x23 scaler multiply
// reset: all state and configuration registers return to their reset values
// at once; items are accepted from the first cycle after reset
// ----------------------------------------------------------------------------
module als_zone_backlight_controller_top (
    input  logic                            clk,
    input  logic                            rst_n,
    azbc_in_if.sink                         in_ch,
    azbc_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [azbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [azbc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import azbc_pkg::*;

    cfg_t    cfg;
    item_t   s1_item_reg;
    logic    s1_valid_reg, s1_valid_next;
    result_t out_res_reg;
    result_t res;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;
    logic    s1_adv;
    logic    in_fire;

    azbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    azbc_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_adv),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // handshake
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_adv      = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input and result payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.cmd          <= in_ch.cmd;
            s1_item_reg.brightness   <= in_ch.brightness;
            s1_item_reg.light_sample <= in_ch.light_sample;
            s1_item_reg.mode_request <= in_ch.mode_request;
        end
        if (s1_adv)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.write_strobe   = out_res_reg.write_strobe;
    assign out_ch.backlight_word = out_res_reg.backlight_word;
    assign out_ch.power_on       = out_res_reg.power_on;
    assign out_ch.zone           = out_res_reg.zone;
    assign out_ch.mode_now       = out_res_reg.mode_now;
    assign out_ch.sensor_invalid = out_res_reg.sensor_invalid;

    // an accepted item is held in the input register next cycle
    ap_accept_loads : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted item lost");

    ap_advance_shows : assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("result not presented");

    ap_invalid_no_write : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.sensor_invalid) |-> !out_res_reg.write_strobe)
        else $error("write on ignored light sample");

    ap_no_strobe_zero_word : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.write_strobe)
            |-> out_res_reg.backlight_word == '0)
        else $error("word set without write");

endmodule

>>> tb/azbc_result_checker.sv
// ----------------------------------------------------------------------------
// azbc_result_checker
// Watches the command and result channels and the register write port of
// the zoned backlight controller, predicts each result item from its own
// copy of the controller state and compares it field by field.
// ----------------------------------------------------------------------------
module azbc_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    azbc_in_if                              in_ch,
    azbc_out_if                             out_ch,
    input  logic                            cfg_we,
    input  logic [azbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [azbc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    import azbc_pkg::*;

    localparam int unsigned PERCENT_FULL = 100;

    // register copies
    logic [PCT_W-1:0]    zone_pct [NUM_ZONES];
    logic [WORD_W-1:0]   base_reg;
    logic [WORD_W-1:0]   off_reg;

    // controller state copies
    logic                auto_mode;
    logic [LEVEL_W-1:0]  saved_level;
    logic [PCT_W-1:0]    pct_now;
    logic [ZONE_W-1:0]   last_zone;
    logic                panel_awake;
    logic                supply_on;

    result_t             backlight_q [$];

    function automatic int unsigned scale_level(input int unsigned lvl);
        return (lvl * pct_now) / PERCENT_FULL;
    endfunction

    // duty in bits five and up, base bits ORed in, kept to the word width
    function automatic logic [WORD_W-1:0] duty_word(input int unsigned lvl);
        logic [31:0] w;
        w = ((lvl / 2) << DUTY_LSB) | base_reg;
        return w[WORD_W-1:0];
    endfunction

    // advance the state copy by one command item and build its result
    function automatic result_t apply_command(input item_t it);
        result_t r;
        int      zone_sel;
        int      i;
        r = '0;
        case (it.cmd)
            CMD_BRIGHT: begin
                r.write_strobe = 1'b1;
                if (it.brightness != '0) begin
                    supply_on   = 1'b1;
                    panel_awake = 1'b1;
                    saved_level = it.brightness;
                    r.backlight_word = auto_mode ? duty_word(scale_level(it.brightness))
                                                 : duty_word(it.brightness);
                end
                else begin
                    supply_on   = 1'b0;
                    panel_awake = 1'b0;
                    r.backlight_word = off_reg;
                end
            end
            CMD_SAMPLE: begin
                zone_sel = NUM_ZONES;
                for (i = NUM_ZONES - 1; i >= 0; i--)
                    if (it.light_sample <= ZONE_LIMIT[i])
                        zone_sel = i;
                if (zone_sel == NUM_ZONES) begin
                    // reading out of range, state untouched
                    r.sensor_invalid = 1'b1;
                end
                else begin
                    pct_now = zone_pct[zone_sel];
                    // zone change rewrites only while the panel is awake
                    if (zone_sel != last_zone && panel_awake) begin
                        r.write_strobe   = 1'b1;
                        r.backlight_word = duty_word(scale_level(saved_level));
                    end
                    last_zone = zone_sel[ZONE_W-1:0];
                end
            end
            CMD_MODE: begin
                r.write_strobe = 1'b1;
                if (it.mode_request) begin
                    auto_mode = 1'b1;
                    r.backlight_word = duty_word(scale_level(saved_level));
                end
                else begin
                    auto_mode = 1'b0;
                    r.backlight_word = duty_word(saved_level);
                end
            end
            default: ;
        endcase
        r.power_on = supply_on;
        r.zone     = last_zone;
        r.mode_now = auto_mode;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // channel and register monitor
    always @(posedge clk or negedge rst_n) begin
        item_t   it;
        result_t want;
        int      i;
        if (!rst_n) begin
            for (i = 0; i < NUM_ZONES; i++)
                zone_pct[i] = PCT_RESET;
            base_reg    = '0;
            off_reg     = '0;
            auto_mode   = 1'b1;
            saved_level = '0;
            pct_now     = '0;
            last_zone   = '0;
            panel_awake = 1'b0;
            supply_on   = 1'b0;
            backlight_q.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index <= REG_ZONE4)
                    zone_pct[cfg_index] = cfg_data[PCT_W-1:0];
                else if (cfg_index == REG_BASE)
                    base_reg = cfg_data;
                else if (cfg_index == REG_OFF)
                    off_reg = cfg_data;
            end

            // result item against the oldest prediction
            if (out_ch.valid && out_ch.ready) begin
                if (backlight_q.size() == 0) begin
                    $display("%0t: result item with no prediction pending", $time);
                    mismatches++;
                end
                else begin
                    want = backlight_q.pop_front();
                    check_field("write_strobe", want.write_strobe, out_ch.write_strobe);
                    check_field("backlight_word", want.backlight_word,
                                out_ch.backlight_word);
                    check_field("power_on", want.power_on, out_ch.power_on);
                    check_field("zone", want.zone, out_ch.zone);
                    check_field("mode_now", want.mode_now, out_ch.mode_now);
                    check_field("sensor_invalid", want.sensor_invalid,
                                out_ch.sensor_invalid);
                end
            end

            // command item accepted
            if (in_ch.valid && in_ch.ready) begin
                it.cmd          = in_ch.cmd;
                it.brightness   = in_ch.brightness;
                it.light_sample = in_ch.light_sample;
                it.mode_request = in_ch.mode_request;
                backlight_q.push_back(apply_command(it));
            end

            outstanding <= backlight_q.size();
        end
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the zoned backlight controller: a directed run over zone
// thresholds, modes and the off path, then random command traffic under
// several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb;
    import azbc_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE      = 3'd7;
    localparam int                   SETTLE_CYCLES = 6;
    localparam int                   STALL_LIMIT   = 5000;
    localparam int                   SEG_ITEMS     = 130;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int sender_gap_pct     = 29;
    int receiver_stall_pct = 77;
    int mismatches;
    int outstanding;
    int quiet_cycles       = 0;

    azbc_in_if  in_ch ();
    azbc_out_if out_ch ();

    als_zone_backlight_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    azbc_result_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // watchdog on cycles with no item or register write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic item_t cmd_item(input logic [CMD_W-1:0] c,
                                       input logic [LEVEL_W-1:0] b,
                                       input logic [SAMPLE_W-1:0] s,
                                       input logic m);
        item_t it;
        it.cmd          = c;
        it.brightness   = b;
        it.light_sample = s;
        it.mode_request = m;
        return it;
    endfunction

    // random command item, unused fields carry random content
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        int unsigned flavor;
        it.cmd          = CMD_W'($urandom);
        it.brightness   = LEVEL_W'($urandom);
        it.light_sample = SAMPLE_W'($urandom);
        it.mode_request = 1'($urandom);
        pick   = $urandom_range(99);
        flavor = $urandom_range(9);
        if (pick < 30)
        begin
            it.cmd = CMD_BRIGHT;
            if (flavor == 0)
                it.brightness = '0;
            else if (flavor == 1)
                it.brightness = '1;
            else
                it.brightness = LEVEL_W'($urandom_range(255, 1));
        end
        else if (pick < 75)
        begin
            it.cmd = CMD_SAMPLE;
            if (flavor < 2)
                it.light_sample = SAMPLE_W'($urandom_range(1023, 751));
            else if (flavor < 4)
                it.light_sample = SAMPLE_W'(ZONE_LIMIT[$urandom_range(NUM_ZONES - 1)] - 1
                                            + $urandom_range(2));
            else
                it.light_sample = SAMPLE_W'($urandom_range(750));
        end
        else if (pick < 95)
            it.cmd = CMD_MODE;
        else
            it.cmd = CMD_UNUSED;
        return it;
    endfunction

    // present one item and hold it until accepted
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= it.cmd;
        in_ch.brightness   <= it.brightness;
        in_ch.light_sample <= it.light_sample;
        in_ch.mode_request <= it.mode_request;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // stop sending and wait until every result item is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all registers for one setting, one per cycle
    task automatic load_setting(input int kind);
        logic [CFG_IDX_W-1:0]  idx [8];
        logic [CFG_DATA_W-1:0] val [8];
        int                    n;
        int                    i;
        n = (kind >= 2) ? 8 : 7;
        for (i = 0; i < NUM_ZONES; i++)
        begin
            idx[i] = REG_ZONE0 + CFG_IDX_W'(i);
            case (kind)
                0:       val[i] = CFG_DATA_W'(PCT_RESET);
                1:       val[i] = (i % 2 == 0) ? 16'h0000 : 16'hff7f;
                default: val[i] = CFG_DATA_W'(($urandom & 16'hff80) | $urandom_range(127));
            endcase
        end
        idx[NUM_ZONES]     = REG_BASE;
        idx[NUM_ZONES + 1] = REG_OFF;
        idx[NUM_ZONES + 2] = REG_NONE;
        case (kind)
            0:
            begin
                val[NUM_ZONES]     = '0;
                val[NUM_ZONES + 1] = '0;
            end
            1:
            begin
                val[NUM_ZONES]     = '1;
                val[NUM_ZONES + 1] = '1;
            end
            default:
            begin
                // keep duty bits visible about half the time
                val[NUM_ZONES]     = $urandom_range(1) ? CFG_DATA_W'($urandom & 16'hf01f)
                                                       : CFG_DATA_W'($urandom);
                val[NUM_ZONES + 1] = CFG_DATA_W'($urandom);
            end
        endcase
        val[NUM_ZONES + 2] = CFG_DATA_W'($urandom);
        for (i = 0; i < n; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        int phase;
        int seg;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.cmd          <= '0;
        in_ch.brightness   <= '0;
        in_ch.light_sample <= '0;
        in_ch.mode_request <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: thresholds, modes, off path, unused command
        send_item(cmd_item(CMD_MODE,   8'd0,   10'd0,    1'b1));  // mode while asleep
        send_item(cmd_item(CMD_SAMPLE, 8'd255, 10'd0,    1'b1));
        send_item(cmd_item(CMD_BRIGHT, 8'd255, 10'd1023, 1'b0));
        send_item(cmd_item(CMD_SAMPLE, 8'd0,   10'd150,  1'b0));
        send_item(cmd_item(CMD_SAMPLE, 8'd0,   10'd151,  1'b0));
        send_item(cmd_item(CMD_SAMPLE, 8'd0,   10'd300,  1'b0));
        send_item(cmd_item(CMD_SAMPLE, 8'd0,   10'd301,  1'b0));
        send_item(cmd_item(CMD_SAMPLE, 8'd0,   10'd450,  1'b0));
        send_item(cmd_item(CMD_SAMPLE, 8'd0,   10'd451,  1'b0));
        send_item(cmd_item(CMD_SAMPLE, 8'd0,   10'd600,  1'b0));
        send_item(cmd_item(CMD_SAMPLE, 8'd0,   10'd601,  1'b0));
        send_item(cmd_item(CMD_SAMPLE, 8'd0,   10'd750,  1'b0));
        send_item(cmd_item(CMD_SAMPLE, 8'd0,   10'd751,  1'b0));  // out of range
        send_item(cmd_item(CMD_SAMPLE, 8'd255, 10'd1023, 1'b1));
        send_item(cmd_item(CMD_MODE,   8'd255, 10'd1023, 1'b0));
        send_item(cmd_item(CMD_SAMPLE, 8'd0,   10'd0,    1'b0));  // manual zone change
        send_item(cmd_item(CMD_BRIGHT, 8'd1,   10'd0,    1'b0));
        send_item(cmd_item(CMD_UNUSED, 8'd255, 10'd1023, 1'b1));
        send_item(cmd_item(CMD_BRIGHT, 8'd0,   10'd0,    1'b1));  // off word
        send_item(cmd_item(CMD_SAMPLE, 8'd0,   10'd700,  1'b0));  // zone change asleep
        send_item(cmd_item(CMD_MODE,   8'd0,   10'd0,    1'b1));
        send_item(cmd_item(CMD_BRIGHT, 8'd128, 10'd512,  1'b0));
        send_item(cmd_item(CMD_MODE,   8'd255, 10'd0,    1'b0));
        drain();

        // random traffic: three idle patterns, four register settings each
        for (phase = 0; phase < 3; phase++)
        begin
            sender_gap_pct     = (phase == 0) ? 29 : (phase == 1) ? 77 : 0;
            receiver_stall_pct = (phase == 0) ? 77 : (phase == 1) ? 29 : 0;
            for (seg = 0; seg < 4; seg++)
            begin
                load_setting(seg);
                repeat (SEG_ITEMS) send_item(random_item());
                drain();
            end
        end

        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
